/* rtl/wslt_pkg.sv */
// ---------------------------------------------------------------------------
// wslt_pkg
// Shared types and constants of the wheel speed and lap tracker: item
// payloads, register indexes, sequencer states and the shared unit's codes.
// ---------------------------------------------------------------------------
package wslt_pkg;

  // field widths
  localparam int TS_W    = 28;
  localparam int SUM_W   = 32;
  localparam int SPD_W   = 24;
  localparam int DIV_W   = 16;
  localparam int CNT_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 28;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LAP_NOISE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWING_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LAPS_GROUP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VALLEY_START = 3'd6;

  // register reset values
  localparam logic [27:0] LAP_NOISE_RST    = 28'd10000;
  localparam logic [15:0] MIN_INTERVAL_RST = 16'd20;
  localparam logic [15:0] NUMERATOR_RST    = 16'd6768;
  localparam logic [7:0]  JUMP_LIMIT_RST   = 8'd10;
  localparam logic [7:0]  SWING_LIMIT_RST  = 8'd10;
  localparam logic [3:0]  LAPS_GROUP_RST   = 4'd3;
  localparam logic [15:0] VALLEY_START_RST = 16'd300;

  // quotient used for a zero interval
  localparam logic [DIV_W-1:0] QUO_SAT = 16'hffff;
  // last divider step
  localparam logic [CNT_W-1:0] DIV_LAST = 4'd15;

  typedef struct packed {
    logic [TS_W-1:0] timestamp_ms;
    logic            start_req;
    logic            lap_event;
    logic            speed_event;
  } in_item_t;

  typedef struct packed {
    logic [TS_W-1:0]  event_time_ms;
    logic             lap_valid;
    logic [SUM_W-1:0] lap_time_ms;
    logic             group_valid;
    logic [SUM_W-1:0] group_total_ms;
    logic             speed_valid;
    logic [SPD_W-1:0] speed_q8;
    logic             extreme_valid;
    logic             extreme_is_peak;
    logic [SPD_W-1:0] extreme_speed_q8;
    logic [TS_W-1:0]  extreme_time_ms;
  } out_item_t;

  typedef enum logic [0:0] {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             carry;   // carry on add, borrow on subtract
    logic [SUM_W-1:0] value;
  } alu_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAP_GAP,
    ST_LAP_CHK,
    ST_LAP_SUM,
    ST_SPD_IV,
    ST_SPD_CHK,
    ST_DIV,
    ST_DIFF,
    ST_DIFF_NEG,
    ST_JUMP,
    ST_AVG,
    ST_VALLEY,
    ST_PEAK,
    ST_SWING_T,
    ST_SWING_CMP,
    ST_EMIT
  } seq_state_t;

endpackage

/* rtl/wslt_alu.sv */
// ---------------------------------------------------------------------------
// wslt_alu
// Shared 32-bit adder/subtractor. The sequencer's gap, sum, divide, difference
// and limit compare steps run through this one unit, one operation per cycle.
// ---------------------------------------------------------------------------
module wslt_alu (
  input  wslt_pkg::alu_req_t req,
  output wslt_pkg::alu_res_t res
);

  logic [wslt_pkg::SUM_W:0] full;

  // carry out on add, borrow out on subtract
  always_comb begin
    if (req.op == wslt_pkg::ALU_ADD) begin
      full = {1'b0, req.a} + {1'b0, req.b};
    end else begin
      full = {1'b0, req.a} - {1'b0, req.b};
    end
    res.carry = full[wslt_pkg::SUM_W];
    res.value = full[wslt_pkg::SUM_W-1:0];
  end

endmodule

/* rtl/wslt_obuf.sv */
// ---------------------------------------------------------------------------
// wslt_obuf
// Result holding register. Keeps a finished item for the receiver so the
// sequencer can take the next input item while the result waits.
// ---------------------------------------------------------------------------
module wslt_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  wslt_pkg::out_item_t load_data,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output wslt_pkg::out_item_t out_data
);

  logic                valid_r;
  wslt_pkg::out_item_t data_r;

  // slot can take a new item when empty or being drained this cycle
  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

/* rtl/wheel_speed_lap_tracker.sv */
// ---------------------------------------------------------------------------
// wheel_speed_lap_tracker
// Turns timestamped lap and wheel pulses into lap times, group totals,
// smoothed Q8 speeds and confirmed speed peaks and valleys.
// ---------------------------------------------------------------------------
// Usage
//   in_*  : one sensor record per item (valid/ready). in_ready is high only
//           while the sequencer is idle.
//   out_* : at most one result item per record (valid/ready), held in an
//           output register; a record that causes nothing gives no item.
//   cfg_* : register write port, taken on any cycle with cfg_wr_en high;
//           write it only while the block is idle.
// Sequence
//   A start record only sets the reference times while idle. A lap-only
//   record runs the gap, noise check and sum steps to the output register.
//   A speed record runs a 16-step restoring divide on the shared
//   adder/subtractor, then the difference, jump, valley, peak and swing steps;
//   a record that also carries a lap runs the lap steps first. A zero or
//   out-of-range interval skips the divide. The next item is taken only in
//   the idle state, after the record in hand has finished.
// Reset
//   rst_n low resets all tracking state and loads the register defaults.
// Stall
//   while out_ready is low the finished item stays in the output register;
//   the next record is still processed and waits in the emit step only if
//   the output register is still full when it finishes.
// ---------------------------------------------------------------------------
module wheel_speed_lap_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  wslt_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output wslt_pkg::out_item_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [wslt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wslt_pkg::CFG_DAT_W-1:0]      cfg_data
);

  // configuration registers
  logic [27:0] lap_noise_r;
  logic [15:0] min_interval_r;
  logic [15:0] numerator_r;
  logic [7:0]  jump_limit_r;
  logic [7:0]  swing_limit_r;
  logic [3:0]  laps_group_r;
  logic [15:0] valley_start_r;

  // tracking state
  logic [wslt_pkg::TS_W-1:0]  last_speed_time_r;
  logic [wslt_pkg::TS_W-1:0]  last_lap_time_r;
  logic [wslt_pkg::SPD_W-1:0] prev_speed_r;
  logic [wslt_pkg::SPD_W-1:0] valley_speed_r;
  logic [wslt_pkg::SPD_W-1:0] peak_speed_r;
  logic [wslt_pkg::TS_W-1:0]  valley_time_r;
  logic [wslt_pkg::TS_W-1:0]  peak_time_r;
  logic                       seeking_peak_r;
  logic [wslt_pkg::CNT_W-1:0] lap_count_r;
  logic [wslt_pkg::SUM_W-1:0] lap_sum_r;

  // working registers
  wslt_pkg::seq_state_t       state_r, state_nxt;
  wslt_pkg::in_item_t         item_r;
  wslt_pkg::out_item_t        res_r;
  logic [wslt_pkg::SUM_W-1:0] tmp_r;
  logic [wslt_pkg::DIV_W-1:0] rem_r;
  logic [wslt_pkg::DIV_W-1:0] quo_r;
  logic [wslt_pkg::CNT_W-1:0] cnt_r;
  logic [wslt_pkg::SPD_W-1:0] s_r;

  wslt_pkg::alu_req_t alu_req;
  wslt_pkg::alu_res_t alu_res;
  wslt_pkg::out_item_t res_init;
  logic               in_fire;
  logic               obuf_free;
  logic               obuf_load;
  logic [wslt_pkg::CNT_W-1:0] count_inc;
  logic [wslt_pkg::DIV_W:0]   div_shift;
  logic [wslt_pkg::SPD_W-1:0] valley_reload;

  assign in_fire       = in_valid && in_ready;
  assign count_inc     = lap_count_r + 4'd1;
  assign div_shift     = {rem_r, quo_r[wslt_pkg::DIV_W-1]};
  assign valley_reload = {valley_start_r, 8'h00};

  // fresh result: only the event time is set
  always_comb begin
    res_init               = '0;
    res_init.event_time_ms = in_data.timestamp_ms;
  end

  wslt_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  wslt_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (obuf_load),
    .load_data (res_r),
    .free      (obuf_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lap_noise_r    <= wslt_pkg::LAP_NOISE_RST;
      min_interval_r <= wslt_pkg::MIN_INTERVAL_RST;
      numerator_r    <= wslt_pkg::NUMERATOR_RST;
      jump_limit_r   <= wslt_pkg::JUMP_LIMIT_RST;
      swing_limit_r  <= wslt_pkg::SWING_LIMIT_RST;
      laps_group_r   <= wslt_pkg::LAPS_GROUP_RST;
      valley_start_r <= wslt_pkg::VALLEY_START_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        wslt_pkg::CFG_LAP_NOISE:    lap_noise_r    <= cfg_data[27:0];
        wslt_pkg::CFG_MIN_INTERVAL: min_interval_r <= cfg_data[15:0];
        wslt_pkg::CFG_NUMERATOR:    numerator_r    <= cfg_data[15:0];
        wslt_pkg::CFG_JUMP_LIMIT:   jump_limit_r   <= cfg_data[7:0];
        wslt_pkg::CFG_SWING_LIMIT:  swing_limit_r  <= cfg_data[7:0];
        wslt_pkg::CFG_LAPS_GROUP:   laps_group_r   <= cfg_data[3:0];
        wslt_pkg::CFG_VALLEY_START: valley_start_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wslt_pkg::ST_IDLE: begin
        if (in_fire && !in_data.start_req) begin
          if (in_data.lap_event) begin
            state_nxt = wslt_pkg::ST_LAP_GAP;
          end else if (in_data.speed_event) begin
            state_nxt = wslt_pkg::ST_SPD_IV;
          end
        end
      end
      wslt_pkg::ST_LAP_GAP: state_nxt = wslt_pkg::ST_LAP_CHK;
      wslt_pkg::ST_LAP_CHK: begin
        // gap below the noise limit drops the whole record
        state_nxt = alu_res.carry ? wslt_pkg::ST_IDLE : wslt_pkg::ST_LAP_SUM;
      end
      wslt_pkg::ST_LAP_SUM: begin
        state_nxt = item_r.speed_event ? wslt_pkg::ST_SPD_IV : wslt_pkg::ST_EMIT;
      end
      wslt_pkg::ST_SPD_IV: state_nxt = wslt_pkg::ST_SPD_CHK;
      wslt_pkg::ST_SPD_CHK: begin
        if (alu_res.carry) begin
          state_nxt = res_r.lap_valid ? wslt_pkg::ST_EMIT : wslt_pkg::ST_IDLE;
        end else if (tmp_r == '0 || tmp_r[wslt_pkg::SUM_W-1:wslt_pkg::DIV_W] != '0) begin
          state_nxt = wslt_pkg::ST_DIFF;
        end else begin
          state_nxt = wslt_pkg::ST_DIV;
        end
      end
      wslt_pkg::ST_DIV: begin
        if (cnt_r == wslt_pkg::DIV_LAST) begin
          state_nxt = wslt_pkg::ST_DIFF;
        end
      end
      wslt_pkg::ST_DIFF: begin
        state_nxt = alu_res.carry ? wslt_pkg::ST_DIFF_NEG : wslt_pkg::ST_JUMP;
      end
      wslt_pkg::ST_DIFF_NEG: state_nxt = wslt_pkg::ST_JUMP;
      wslt_pkg::ST_JUMP: begin
        // limit below the difference means a jump
        state_nxt = alu_res.carry ? wslt_pkg::ST_AVG : wslt_pkg::ST_VALLEY;
      end
      wslt_pkg::ST_AVG:       state_nxt = wslt_pkg::ST_VALLEY;
      wslt_pkg::ST_VALLEY:    state_nxt = wslt_pkg::ST_PEAK;
      wslt_pkg::ST_PEAK:      state_nxt = wslt_pkg::ST_SWING_T;
      wslt_pkg::ST_SWING_T:   state_nxt = wslt_pkg::ST_SWING_CMP;
      wslt_pkg::ST_SWING_CMP: state_nxt = wslt_pkg::ST_EMIT;
      wslt_pkg::ST_EMIT: begin
        if (obuf_free) begin
          state_nxt = wslt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wslt_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and shared unit operands
  always_comb begin
    in_ready    = 1'b0;
    obuf_load   = 1'b0;
    alu_req.op  = wslt_pkg::ALU_SUB;
    alu_req.a   = '0;
    alu_req.b   = '0;
    case (state_r)
      wslt_pkg::ST_IDLE: in_ready = 1'b1;
      wslt_pkg::ST_LAP_GAP: begin
        alu_req.a = {4'h0, item_r.timestamp_ms};
        alu_req.b = {4'h0, last_lap_time_r};
      end
      wslt_pkg::ST_LAP_CHK: begin
        alu_req.a = tmp_r;
        alu_req.b = {4'h0, lap_noise_r};
      end
      wslt_pkg::ST_LAP_SUM: begin
        alu_req.op = wslt_pkg::ALU_ADD;
        alu_req.a  = lap_sum_r;
        alu_req.b  = tmp_r;
      end
      wslt_pkg::ST_SPD_IV: begin
        alu_req.a = {4'h0, item_r.timestamp_ms};
        alu_req.b = {4'h0, last_speed_time_r};
      end
      wslt_pkg::ST_SPD_CHK: begin
        alu_req.a = tmp_r;
        alu_req.b = {16'h0, min_interval_r};
      end
      wslt_pkg::ST_DIV: begin
        alu_req.a = {15'h0, div_shift};
        alu_req.b = {16'h0, tmp_r[wslt_pkg::DIV_W-1:0]};
      end
      wslt_pkg::ST_DIFF: begin
        alu_req.a = {8'h0, quo_r, 8'h00};
        alu_req.b = {8'h0, prev_speed_r};
      end
      wslt_pkg::ST_DIFF_NEG: begin
        alu_req.a = {8'h0, prev_speed_r};
        alu_req.b = {8'h0, s_r};
      end
      wslt_pkg::ST_JUMP: begin
        alu_req.a = {16'h0, jump_limit_r, 8'h00};
        alu_req.b = tmp_r;
      end
      wslt_pkg::ST_AVG: begin
        alu_req.op = wslt_pkg::ALU_ADD;
        alu_req.a  = {8'h0, s_r};
        alu_req.b  = {8'h0, prev_speed_r};
      end
      wslt_pkg::ST_VALLEY: begin
        alu_req.a = {8'h0, s_r};
        alu_req.b = {8'h0, valley_speed_r};
      end
      wslt_pkg::ST_PEAK: begin
        alu_req.a = {8'h0, peak_speed_r};
        alu_req.b = {8'h0, s_r};
      end
      wslt_pkg::ST_SWING_T: begin
        if (seeking_peak_r) begin
          alu_req.a = {8'h0, peak_speed_r};
          alu_req.b = {8'h0, s_r};
        end else begin
          alu_req.a = {8'h0, s_r};
          alu_req.b = {8'h0, valley_speed_r};
        end
      end
      wslt_pkg::ST_SWING_CMP: begin
        alu_req.a = {16'h0, swing_limit_r, 8'h00};
        alu_req.b = tmp_r;
      end
      wslt_pkg::ST_EMIT: obuf_load = obuf_free;
      default: ;
    endcase
  end

  // state register and tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= wslt_pkg::ST_IDLE;
      last_speed_time_r <= '0;
      last_lap_time_r   <= '0;
      prev_speed_r      <= '0;
      valley_speed_r    <= {wslt_pkg::VALLEY_START_RST, 8'h00};
      peak_speed_r      <= '0;
      valley_time_r     <= '0;
      peak_time_r       <= '0;
      seeking_peak_r    <= 1'b1;
      lap_count_r       <= '0;
      lap_sum_r         <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        wslt_pkg::ST_IDLE: begin
          // start record only sets the reference times
          if (in_fire && in_data.start_req) begin
            last_speed_time_r <= in_data.timestamp_ms;
            last_lap_time_r   <= in_data.timestamp_ms;
          end
        end
        wslt_pkg::ST_LAP_SUM: begin
          last_lap_time_r <= item_r.timestamp_ms;
          if (count_inc == laps_group_r) begin
            lap_sum_r   <= '0;
            lap_count_r <= '0;
          end else begin
            lap_sum_r   <= alu_res.value;
            lap_count_r <= count_inc;
          end
        end
        wslt_pkg::ST_VALLEY: begin
          if (alu_res.carry) begin
            valley_speed_r <= s_r;
            valley_time_r  <= item_r.timestamp_ms;
          end
        end
        wslt_pkg::ST_PEAK: begin
          if (alu_res.carry) begin
            peak_speed_r <= s_r;
            peak_time_r  <= item_r.timestamp_ms;
          end
        end
        wslt_pkg::ST_SWING_CMP: begin
          last_speed_time_r <= item_r.timestamp_ms;
          prev_speed_r      <= s_r;
          if (alu_res.carry) begin
            peak_speed_r   <= '0;
            valley_speed_r <= valley_reload;
            seeking_peak_r <= !seeking_peak_r;
          end
        end
        default: ;
      endcase
    end
  end

  // working datapath and result assembly
  always_ff @(posedge clk) begin
    case (state_r)
      wslt_pkg::ST_IDLE: begin
        if (in_fire) begin
          item_r <= in_data;
          res_r  <= res_init;
        end
      end
      wslt_pkg::ST_LAP_GAP: tmp_r <= alu_res.value;
      wslt_pkg::ST_LAP_SUM: begin
        res_r.lap_valid   <= 1'b1;
        res_r.lap_time_ms <= tmp_r;
        if (count_inc == laps_group_r) begin
          res_r.group_valid    <= 1'b1;
          res_r.group_total_ms <= alu_res.value;
        end
      end
      wslt_pkg::ST_SPD_IV: tmp_r <= alu_res.value;
      wslt_pkg::ST_SPD_CHK: begin
        rem_r <= '0;
        cnt_r <= '0;
        if (tmp_r == '0) begin
          quo_r <= wslt_pkg::QUO_SAT;
        end else if (tmp_r[wslt_pkg::SUM_W-1:wslt_pkg::DIV_W] != '0) begin
          quo_r <= '0;
        end else begin
          quo_r <= numerator_r;
        end
      end
      wslt_pkg::ST_DIV: begin
        // one restoring step: numerator bits leave quo_r, quotient bits enter
        cnt_r <= cnt_r + 4'd1;
        if (alu_res.carry) begin
          rem_r <= div_shift[wslt_pkg::DIV_W-1:0];
          quo_r <= {quo_r[wslt_pkg::DIV_W-2:0], 1'b0};
        end else begin
          rem_r <= alu_res.value[wslt_pkg::DIV_W-1:0];
          quo_r <= {quo_r[wslt_pkg::DIV_W-2:0], 1'b1};
        end
      end
      wslt_pkg::ST_DIFF: begin
        s_r   <= {quo_r, 8'h00};
        tmp_r <= alu_res.value;
      end
      wslt_pkg::ST_DIFF_NEG: tmp_r <= alu_res.value;
      wslt_pkg::ST_AVG: s_r <= alu_res.value[wslt_pkg::SPD_W:1];
      wslt_pkg::ST_SWING_T: tmp_r <= alu_res.value;
      wslt_pkg::ST_SWING_CMP: begin
        res_r.speed_valid <= 1'b1;
        res_r.speed_q8    <= s_r;
        if (alu_res.carry) begin
          res_r.extreme_valid   <= 1'b1;
          res_r.extreme_is_peak <= seeking_peak_r;
          res_r.extreme_speed_q8 <= seeking_peak_r ? peak_speed_r : valley_speed_r;
          res_r.extreme_time_ms  <= seeking_peak_r ? peak_time_r : valley_time_r;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  // a start record never leaves the idle state
  a_start_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.start_req) |=> (state_r == wslt_pkg::ST_IDLE))
    else $error("start record left idle state");

  // the divider runs exactly sixteen steps
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wslt_pkg::ST_DIV && cnt_r == wslt_pkg::DIV_LAST)
    |=> (state_r == wslt_pkg::ST_DIFF))
    else $error("divider overran its step count");

  // every loaded result carries a lap or a speed
  a_load_has_content: assert property (@(posedge clk) disable iff (!rst_n)
    obuf_load |-> (res_r.lap_valid || res_r.speed_valid))
    else $error("empty result loaded");

  // a group total only comes with a lap, an extreme only with a speed
  a_flag_deps: assert property (@(posedge clk) disable iff (!rst_n)
    obuf_load |-> ((!res_r.group_valid || res_r.lap_valid)
                && (!res_r.extreme_valid || res_r.speed_valid)))
    else $error("result flags inconsistent");

  // the output register is never overwritten while it still holds an item
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (obuf_load && out_valid) |-> out_ready)
    else $error("output register overwritten");
`endif

endmodule

/* verif/tb_wheel_speed_lap_tracker.sv */
// ---------------------------------------------------------------------------
// tb_wheel_speed_lap_tracker
// Self-checking bench for the wheel speed and lap tracker. A scoreboard class
// keeps its own copy of the registers and tracking state. It predicts the
// result of every accepted sensor record and checks each result item field by
// field in order. Stimulus is a short directed run followed by random record
// streams under several register settings, including the extremes. Both
// channels idle and stall at random, and one long receiver hold-off fills the
// block.
// ---------------------------------------------------------------------------
module tb_wheel_speed_lap_tracker;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_LIMIT   = 6000;

  // expected-result bookkeeping and prediction
  class lap_speed_scoreboard_t;
    // register copies
    logic [27:0] lap_noise;
    logic [15:0] min_iv;
    logic [15:0] numer;
    logic [7:0]  jump_lim;
    logic [7:0]  swing_lim;
    logic [3:0]  group_size;
    logic [15:0] valley_init;
    // tracking state
    logic [27:0] last_spd_t;
    logic [27:0] last_lap_t;
    logic [27:0] valley_t;
    logic [27:0] peak_t;
    logic [23:0] prev_spd;
    logic [23:0] valley_spd;
    logic [23:0] peak_spd;
    bit          hunting_peak;
    logic [3:0]  lap_cnt;
    logic [31:0] lap_sum;
    wslt_pkg::out_item_t pending_results[$];
    int          errors;

    function new();
      lap_noise    = wslt_pkg::LAP_NOISE_RST;
      min_iv       = wslt_pkg::MIN_INTERVAL_RST;
      numer        = wslt_pkg::NUMERATOR_RST;
      jump_lim     = wslt_pkg::JUMP_LIMIT_RST;
      swing_lim    = wslt_pkg::SWING_LIMIT_RST;
      group_size   = wslt_pkg::LAPS_GROUP_RST;
      valley_init  = wslt_pkg::VALLEY_START_RST;
      last_spd_t   = '0;
      last_lap_t   = '0;
      valley_t     = '0;
      peak_t       = '0;
      prev_spd     = '0;
      valley_spd   = {wslt_pkg::VALLEY_START_RST, 8'h00};
      peak_spd     = '0;
      hunting_peak = 1'b1;
      lap_cnt      = '0;
      lap_sum      = '0;
      errors       = 0;
    endfunction

    function void set_reg(input logic [wslt_pkg::CFG_IDX_W-1:0] idx,
                          input logic [wslt_pkg::CFG_DAT_W-1:0] val);
      case (idx)
        wslt_pkg::CFG_LAP_NOISE:    lap_noise   = val[27:0];
        wslt_pkg::CFG_MIN_INTERVAL: min_iv      = val[15:0];
        wslt_pkg::CFG_NUMERATOR:    numer       = val[15:0];
        wslt_pkg::CFG_JUMP_LIMIT:   jump_lim    = val[7:0];
        wslt_pkg::CFG_SWING_LIMIT:  swing_lim   = val[7:0];
        wslt_pkg::CFG_LAPS_GROUP:   group_size  = val[3:0];
        wslt_pkg::CFG_VALLEY_START: valley_init = val[15:0];
        default: ;
      endcase
    endfunction

    // advance the tracking state by one record, return 1 when it gives a result
    function bit track_record(input wslt_pkg::in_item_t it, output wslt_pkg::out_item_t r);
      logic [31:0] gap;
      logic [31:0] iv;
      logic [31:0] quo;
      logic [31:0] sum;
      logic [23:0] spd;
      logic [23:0] dif;
      logic [23:0] swing;
      bit          emit;
      r    = '0;
      emit = 1'b0;

      // start record only sets the reference times
      if (it.start_req) begin
        last_spd_t = it.timestamp_ms;
        last_lap_t = it.timestamp_ms;
        return 1'b0;
      end

      // lap: a gap below the noise limit drops the whole record
      if (it.lap_event) begin
        gap = {4'h0, it.timestamp_ms} - {4'h0, last_lap_t};
        if (gap < {4'h0, lap_noise})
          return 1'b0;
        r.lap_valid   = 1'b1;
        r.lap_time_ms = gap;
        lap_sum       = lap_sum + gap;
        lap_cnt       = lap_cnt + 4'd1;
        if (lap_cnt == group_size) begin
          r.group_valid    = 1'b1;
          r.group_total_ms = lap_sum;
          lap_sum          = '0;
          lap_cnt          = '0;
        end
        last_lap_t = it.timestamp_ms;
        emit       = 1'b1;
      end

      // speed: quotient to Q8, jump smoothing, then peak and valley tracking
      if (it.speed_event) begin
        iv = {4'h0, it.timestamp_ms} - {4'h0, last_spd_t};
        if (iv >= {16'h0, min_iv}) begin
          quo   = (iv != 32'd0) ? {16'h0, numer} / iv : 32'h0000ffff;
          spd   = {quo[15:0], 8'h00};
          dif   = (spd > prev_spd) ? spd - prev_spd : prev_spd - spd;
          swing = {8'h00, swing_lim, 8'h00};
          if (dif > {8'h00, jump_lim, 8'h00}) begin
            sum = {8'h00, spd} + {8'h00, prev_spd};
            spd = sum[24:1];
          end
          if (spd < valley_spd) begin
            valley_spd = spd;
            valley_t   = it.timestamp_ms;
          end
          if (spd > peak_spd) begin
            peak_spd = spd;
            peak_t   = it.timestamp_ms;
          end
          if (hunting_peak) begin
            if (peak_spd > spd && peak_spd - spd > swing) begin
              r.extreme_valid    = 1'b1;
              r.extreme_is_peak  = 1'b1;
              r.extreme_speed_q8 = peak_spd;
              r.extreme_time_ms  = peak_t;
              peak_spd           = '0;
              valley_spd         = {valley_init, 8'h00};
              hunting_peak       = 1'b0;
            end
          end else if (spd > valley_spd && spd - valley_spd > swing) begin
            r.extreme_valid    = 1'b1;
            r.extreme_is_peak  = 1'b0;
            r.extreme_speed_q8 = valley_spd;
            r.extreme_time_ms  = valley_t;
            valley_spd         = {valley_init, 8'h00};
            peak_spd           = '0;
            hunting_peak       = 1'b1;
          end
          r.speed_valid = 1'b1;
          r.speed_q8    = spd;
          last_spd_t    = it.timestamp_ms;
          prev_spd      = spd;
          emit          = 1'b1;
        end
      end

      if (emit)
        r.event_time_ms = it.timestamp_ms;
      return emit;
    endfunction

    function void note_input(input wslt_pkg::in_item_t it);
      wslt_pkg::out_item_t r;
      if (track_record(it, r))
        pending_results.push_back(r);
    endfunction

    task report_mismatch(input string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task compare_field(input string name, input logic [31:0] got, input logic [31:0] want,
                       input logic [27:0] at);
      if (got !== want)
        report_mismatch($sformatf("%s at event %0h: got %0h expected %0h", name, at, got, want));
    endtask

    task check_result(input wslt_pkg::out_item_t got);
      wslt_pkg::out_item_t want;
      logic [27:0]         at;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, event %0h", got.event_time_ms));
        return;
      end
      want = pending_results.pop_front();
      at   = want.event_time_ms;
      compare_field("event_time_ms", 32'(got.event_time_ms), 32'(want.event_time_ms), at);
      compare_field("lap_valid", 32'(got.lap_valid), 32'(want.lap_valid), at);
      compare_field("lap_time_ms", got.lap_time_ms, want.lap_time_ms, at);
      compare_field("group_valid", 32'(got.group_valid), 32'(want.group_valid), at);
      compare_field("group_total_ms", got.group_total_ms, want.group_total_ms, at);
      compare_field("speed_valid", 32'(got.speed_valid), 32'(want.speed_valid), at);
      compare_field("speed_q8", 32'(got.speed_q8), 32'(want.speed_q8), at);
      compare_field("extreme_valid", 32'(got.extreme_valid), 32'(want.extreme_valid), at);
      compare_field("extreme_is_peak", 32'(got.extreme_is_peak), 32'(want.extreme_is_peak),
                    at);
      compare_field("extreme_speed_q8", 32'(got.extreme_speed_q8),
                    32'(want.extreme_speed_q8), at);
      compare_field("extreme_time_ms", 32'(got.extreme_time_ms), 32'(want.extreme_time_ms),
                    at);
    endtask

    task flush_missing();
      wslt_pkg::out_item_t r;
      while (pending_results.size() != 0) begin
        r = pending_results.pop_front();
        report_mismatch($sformatf("result never arrived, event %0h", r.event_time_ms));
      end
    endtask
  endclass

  typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  wslt_pkg::in_item_t     in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  wslt_pkg::out_item_t    out_data;
  logic                   cfg_wr_en = 1'b0;
  logic [wslt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [wslt_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  lap_speed_scoreboard_t  sb;
  int unsigned            cycle_count = 0;
  int                     burst_left = 0;
  bit                     long_hold_req = 1'b0;
  bit                     long_hold_done = 1'b0;
  int                     stall_left = 0;
  int                     mode_left = 0;
  rx_mode_t               rx_mode = RX_OPEN;
  logic [15:0]            ready_pat = 16'h0001;
  // record stream state
  logic [27:0]            tnow = '0;
  int                     iv_cur = 0;
  longint                 since_lap = 0;
  longint                 lap_due = 0;

  wheel_speed_lap_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: check accepted results, then pick the next ready value
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_data);
    if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      stall_left     = LONG_HOLD;
    end
    if (mode_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 2));
      mode_left = $urandom_range(32, 300);
      ready_pat = 16'($urandom) | 16'h0001;
    end else begin
      mode_left--;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
        default: begin
          out_ready <= ready_pat[0];
          ready_pat = {ready_pat[0], ready_pat[15:1]};
        end
      endcase
    end
  end

  // offer one item, with a random gap at the start of each burst
  task automatic offer(input wslt_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    burst_left--;
  endtask

  task automatic rec(input logic [27:0] ts, input bit st, input bit lp, input bit sp);
    wslt_pkg::in_item_t it;
    it.timestamp_ms = ts;
    it.start_req    = st;
    it.lap_event    = lp;
    it.speed_event  = sp;
    offer(it);
  endtask

  // wait until every expected item is back and the block has gone quiet
  task automatic settle_block();
    int waited;
    waited   = 0;
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    sb.flush_missing();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [wslt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wslt_pkg::CFG_DAT_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [27:0] noise, input logic [15:0] min_interval,
                               input logic [15:0] num, input logic [7:0] jump,
                               input logic [7:0] swing, input logic [3:0] group,
                               input logic [15:0] valley);
    write_reg(wslt_pkg::CFG_LAP_NOISE, noise);
    write_reg(wslt_pkg::CFG_MIN_INTERVAL, 28'(min_interval));
    write_reg(wslt_pkg::CFG_NUMERATOR, 28'(num));
    write_reg(wslt_pkg::CFG_JUMP_LIMIT, 28'(jump));
    write_reg(wslt_pkg::CFG_SWING_LIMIT, 28'(swing));
    write_reg(wslt_pkg::CFG_LAPS_GROUP, 28'(group));
    write_reg(wslt_pkg::CFG_VALLEY_START, 28'(valley));
    cfg_wr_en <= 1'b0;
  endtask

  // random record stream: mostly a steady ride with a wandering wheel interval
  // and periodic laps, plus restarts, garbage, repeated stamps and empty records
  task automatic random_run(input int count, input int iv_lo, input int iv_hi,
                            input int lap_lo, input int lap_hi);
    wslt_pkg::in_item_t it;
    int       pick;
    int       stp;
    stp     = (iv_hi - iv_lo) / 16 + 1;
    iv_cur  = $urandom_range(iv_lo, iv_hi);
    lap_due = longint'($urandom_range(lap_lo, lap_hi));
    for (int n = 0; n < count; n++) begin
      it   = '0;
      pick = $urandom_range(0, 99);
      if (pick < 84) begin
        if ($urandom_range(0, 15) == 0)
          iv_cur = $urandom_range(iv_lo, iv_hi);
        else
          iv_cur = iv_cur + int'($urandom_range(0, 2 * stp)) - stp;
        if (iv_cur < iv_lo) iv_cur = iv_lo;
        if (iv_cur > iv_hi) iv_cur = iv_hi;
        tnow            = tnow + 28'(iv_cur);
        since_lap       = since_lap + iv_cur;
        it.timestamp_ms = tnow;
        it.speed_event  = ($urandom_range(0, 15) != 0);
        if (since_lap >= lap_due) begin
          it.lap_event = 1'b1;
          since_lap    = 0;
          lap_due      = longint'($urandom_range(lap_lo, lap_hi));
        end
      end else if (pick < 89) begin
        // restart of the reference times
        tnow            = tnow + 28'($urandom_range(0, 50));
        it.timestamp_ms = tnow;
        it.start_req    = 1'b1;
        it.lap_event    = 1'($urandom_range(0, 1));
        it.speed_event  = 1'($urandom_range(0, 1));
        since_lap       = 0;
      end else if (pick < 94) begin
        // garbage record
        it.timestamp_ms = 28'($urandom);
        it.start_req    = ($urandom_range(0, 7) == 0);
        it.lap_event    = 1'($urandom_range(0, 1));
        it.speed_event  = 1'($urandom_range(0, 1));
      end else if (pick < 97) begin
        // same stamp again
        it.timestamp_ms = tnow;
        it.lap_event    = 1'($urandom_range(0, 1));
        it.speed_event  = 1'b1;
      end else begin
        // no flags at all
        tnow            = tnow + 28'($urandom_range(1, 100));
        it.timestamp_ms = tnow;
      end
      offer(it);
    end
  endtask

  // main sequence
  initial begin
    int ramp_ms [13];
    ramp_ms = '{50, 40, 30, 22, 20, 20, 26, 40, 60, 80, 80, 50, 30};
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed run on the reset settings
    rec(28'd0, 1'b0, 1'b0, 1'b0);          // no flags
    rec(28'h0fffffff, 1'b1, 1'b1, 1'b1);   // start at top of range, other flags ignored
    rec(28'd5, 1'b0, 1'b1, 1'b1);          // time runs backward: huge lap, zero speed
    rec(28'd1000, 1'b1, 1'b0, 1'b0);       // restart
    rec(28'd1010, 1'b0, 1'b0, 1'b1);       // interval too short
    tnow = 28'd1010;
    // speed ramp up then down then up: jumps, a peak and a valley
    for (int k = 0; k < 13; k++) begin
      tnow = tnow + 28'(ramp_ms[k]);
      rec(tnow, 1'b0, 1'b0, 1'b1);
    end
    tnow = tnow + 28'd50;
    rec(tnow, 1'b0, 1'b1, 1'b1);           // lap noise drops the speed part too
    rec(28'd10999, 1'b0, 1'b1, 1'b0);      // one short of the noise limit
    rec(28'd11000, 1'b0, 1'b1, 1'b1);      // exactly at the limit, lap and speed together
    rec(28'd21000, 1'b0, 1'b1, 1'b0);      // closes a group
    rec(28'd3, 1'b0, 1'b1, 1'b0);          // backward laps: group sum wraps
    rec(28'd2, 1'b0, 1'b1, 1'b0);
    rec(28'd12002, 1'b0, 1'b1, 1'b0);
    tnow = 28'd12002;
    random_run(150, 20, 300, 8000, 14000);
    settle_block();

    // typical ride with short laps, receiver held off for a long stretch
    load_settings(28'd500, 16'd20, 16'd6768, 8'd10, 8'd10, 4'd3, 16'd300);
    long_hold_req = 1'b1;
    random_run(350, 15, 200, 400, 900);
    settle_block();

    // low extremes: no noise limit, no jump or swing margin, one lap per group
    load_settings(28'd0, 16'd1, 16'd65535, 8'd0, 8'd0, 4'd1, 16'd0);
    random_run(200, 0, 300, 0, 300);
    settle_block();

    // high extremes: only backward laps get through
    load_settings(28'h0fffffff, 16'd65535, 16'd65535, 8'd255, 8'd255, 4'd0, 16'd65535);
    random_run(150, 60000, 70000, 500000, 900000);
    settle_block();

    // zero minimum interval, unit numerator, groups of sixteen laps
    load_settings(28'd1000, 16'd0, 16'd1, 8'd255, 8'd0, 4'd0, 16'd0);
    tnow = tnow + 28'd10;
    rec(tnow, 1'b1, 1'b0, 1'b0);
    for (int k = 0; k < 17; k++) begin
      tnow = tnow + 28'd1200;
      rec(tnow, 1'b0, 1'b1, 1'b0);
    end
    rec(tnow, 1'b0, 1'b0, 1'b1);           // long interval: zero quotient; the repeat has zero interval and saturates
    rec(tnow, 1'b0, 1'b0, 1'b1);
    random_run(200, 0, 60, 1000, 1100);
    settle_block();

    // mid settings with a different valley start
    load_settings(28'd5000, 16'd40, 16'd20000, 8'd30, 8'd20, 4'd5, 16'd500);
    random_run(250, 20, 400, 4000, 7000);
    settle_block();

    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* filelist.f */
rtl/wslt_pkg.sv
rtl/wslt_alu.sv
rtl/wslt_obuf.sv
rtl/wheel_speed_lap_tracker.sv
verif/tb_wheel_speed_lap_tracker.sv
